FILE: rtl/drive_power_state_machine_defines.svh
// assertion macros for the drive power state machine
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef DRIVE_POWER_STATE_MACHINE_DEFINES_SVH
`define DRIVE_POWER_STATE_MACHINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DPSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dpsm: same-cycle check failed");

// next-cycle implication, checked out of reset
`define DPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dpsm: next-cycle check failed");

`endif

FILE: rtl/dpsm_pkg.sv
// shared types, codes and status masks of the drive power state machine
// no dependencies
`timescale 1ns / 1ps

package dpsm_pkg;

    // object write commands
    localparam logic [1:0] CMD_CONTROL_WORD = 2'd0;
    localparam logic [1:0] CMD_OP_MODE      = 2'd1;

    // control word bit positions
    localparam int CW_SO   = 0;
    localparam int CW_EV   = 1;
    localparam int CW_QS   = 2;
    localparam int CW_EO   = 3;
    localparam int CW_NSP  = 4;
    localparam int CW_REL  = 6;
    localparam int CW_FR   = 7;
    localparam int CW_HALT = 8;

    // status word masks
    localparam logic [15:0] SB_RTSO  = 16'h0001;
    localparam logic [15:0] SB_SO    = 16'h0002;
    localparam logic [15:0] SB_OE    = 16'h0004;
    localparam logic [15:0] SB_FAULT = 16'h0008;
    localparam logic [15:0] SB_QS    = 16'h0020;
    localparam logic [15:0] SB_SOD   = 16'h0040;

    // operation modes
    localparam logic [7:0] MODE_PROFILE_VEL = 8'd3;
    localparam logic [7:0] MODE_PROFILE_TRQ = 8'd4;
    localparam logic [7:0] MODE_MAX         = 8'd10;

    typedef enum logic [2:0] {
        ST_NOT_READY      = 3'd0,
        ST_DISABLED       = 3'd1,
        ST_READY          = 3'd2,
        ST_SWITCHED_ON    = 3'd3,
        ST_ENABLED        = 3'd4,
        ST_QUICK_STOP     = 3'd5,
        ST_FAULT_REACTION = 3'd6,
        ST_FAULT          = 3'd7
    } t_drive_state;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_VEL  = 2'd2,
        ACT_TRQ  = 2'd3
    } t_motor_action;

    typedef struct packed {
        t_drive_state state;
        logic [15:0]  status;
        logic [7:0]   active_mode;
        logic [7:0]   tracked_mode;
        logic [7:0]   shown_mode;
        logic         halt;
        logic         relative;
        logic         setpoint;
    } t_drive_regs;

    typedef struct packed {
        logic [15:0]   stat_bits;
        t_drive_state  drive_state;
        logic [7:0]    mode_display;
        logic          mode_rejected;
        logic          halt_flag;
        logic          relative_flag;
        logic          new_setpoint_flag;
        t_motor_action motor_action;
    } t_result;

    // status bits set on entry to a state
    function automatic logic [15:0] entry_set(input t_drive_state st);
        logic [15:0] m;
        unique case (st)
            ST_DISABLED:    m = SB_SOD;
            ST_READY:       m = SB_RTSO | SB_QS;
            ST_SWITCHED_ON: m = SB_RTSO | SB_SO | SB_QS;
            ST_ENABLED:     m = SB_RTSO | SB_SO | SB_OE | SB_QS;
            ST_QUICK_STOP:  m = SB_RTSO | SB_SO | SB_OE;
            default:        m = '0;
        endcase
        return m;
    endfunction

    // status bits cleared on entry to a state
    function automatic logic [15:0] entry_clr(input t_drive_state st);
        logic [15:0] m;
        unique case (st)
            ST_DISABLED:    m = SB_RTSO | SB_SO | SB_OE | SB_FAULT;
            ST_READY:       m = SB_SO | SB_OE | SB_FAULT | SB_SOD;
            ST_SWITCHED_ON: m = SB_OE | SB_FAULT | SB_SOD;
            ST_ENABLED:     m = SB_FAULT | SB_SOD;
            ST_QUICK_STOP:  m = SB_FAULT | SB_QS | SB_SOD;
            default:        m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/dpsm_core.sv
// next-state and result logic for one object write
// depends on dpsm_pkg
`timescale 1ns / 1ps

module dpsm_core (
    input  dpsm_pkg::t_drive_regs i_regs,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_sub_index,
    input  logic [15:0]           i_write_value,
    output dpsm_pkg::t_drive_regs o_regs,
    output dpsm_pkg::t_result     o_result
);

    logic                    cw_shutdown;
    logic                    cw_disable;
    logic                    cw_swon;
    logic                    cw_enable_op;
    logic                    cw_qstop;
    logic                    cw_freset;
    logic                    is_control;
    logic                    is_mode;
    logic                    mode_ok;
    logic                    take_go;
    dpsm_pkg::t_drive_state  target;
    dpsm_pkg::t_motor_action act;
    logic                    rejected;
    logic [15:0]             cw;
    logic [7:0]              mode_byte;

    assign cw        = i_write_value;
    assign mode_byte = i_write_value[7:0];

    assign cw_shutdown  = !cw[dpsm_pkg::CW_FR] && cw[dpsm_pkg::CW_QS]
                          && cw[dpsm_pkg::CW_EV] && !cw[dpsm_pkg::CW_SO];
    assign cw_disable   = !cw[dpsm_pkg::CW_FR] && !cw[dpsm_pkg::CW_EV];
    assign cw_swon      = !cw[dpsm_pkg::CW_FR] && !cw[dpsm_pkg::CW_EO]
                          && cw[dpsm_pkg::CW_QS] && cw[dpsm_pkg::CW_EV]
                          && cw[dpsm_pkg::CW_SO];
    assign cw_enable_op = !cw[dpsm_pkg::CW_FR] && cw[dpsm_pkg::CW_EO]
                          && cw[dpsm_pkg::CW_QS] && cw[dpsm_pkg::CW_EV]
                          && cw[dpsm_pkg::CW_SO];
    assign cw_qstop     = !cw[dpsm_pkg::CW_FR] && !cw[dpsm_pkg::CW_QS]
                          && cw[dpsm_pkg::CW_EV];
    assign cw_freset    = cw[dpsm_pkg::CW_FR];

    assign is_control = (i_sub_index == 8'd0) && (i_command == dpsm_pkg::CMD_CONTROL_WORD);
    assign is_mode    = (i_sub_index == 8'd0) && (i_command == dpsm_pkg::CMD_OP_MODE);
    // signed byte in 0..10
    assign mode_ok    = !mode_byte[7] && (mode_byte <= dpsm_pkg::MODE_MAX);

    always_comb begin
        o_regs   = i_regs;
        take_go  = 1'b0;
        target   = i_regs.state;
        act      = dpsm_pkg::ACT_NONE;
        rejected = 1'b0;

        if (is_control) begin
            // the transition tests of each state never match together
            unique case (i_regs.state)
                dpsm_pkg::ST_NOT_READY: begin
                    take_go = 1'b1;
                    target  = dpsm_pkg::ST_DISABLED;
                end
                dpsm_pkg::ST_DISABLED: begin
                    if (cw_shutdown) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_READY;
                    end
                end
                dpsm_pkg::ST_READY: begin
                    if (cw_freset) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_READY;
                    end else if (cw_swon) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_SWITCHED_ON;
                    end else if (cw_disable) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_DISABLED;
                    end
                end
                dpsm_pkg::ST_SWITCHED_ON: begin
                    if (cw_enable_op) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_ENABLED;
                    end else if (cw_shutdown) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_READY;
                    end else if (cw_disable) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_DISABLED;
                    end
                end
                dpsm_pkg::ST_ENABLED: begin
                    if (cw_qstop) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_QUICK_STOP;
                        act     = dpsm_pkg::ACT_STOP;
                    end else if (cw_swon) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_SWITCHED_ON;
                    end else if (cw_shutdown) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_READY;
                    end else if (cw_disable) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_DISABLED;
                    end
                    o_regs.relative = cw[dpsm_pkg::CW_REL];
                    o_regs.halt     = cw[dpsm_pkg::CW_HALT];
                    o_regs.setpoint = cw[dpsm_pkg::CW_NSP];
                    // mode change seen while running: stop, maybe restart
                    if (i_regs.tracked_mode != i_regs.active_mode) begin
                        o_regs.tracked_mode = i_regs.active_mode;
                        priority if (i_regs.active_mode == dpsm_pkg::MODE_PROFILE_VEL) begin
                            act = dpsm_pkg::ACT_VEL;
                        end else if (i_regs.active_mode == dpsm_pkg::MODE_PROFILE_TRQ) begin
                            act = dpsm_pkg::ACT_TRQ;
                        end else begin
                            act = dpsm_pkg::ACT_STOP;
                        end
                    end
                end
                dpsm_pkg::ST_QUICK_STOP: begin
                    if (cw_disable) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_DISABLED;
                    end else if (cw_enable_op) begin
                        take_go = 1'b1;
                        target  = dpsm_pkg::ST_ENABLED;
                    end
                end
                dpsm_pkg::ST_FAULT_REACTION, dpsm_pkg::ST_FAULT: begin
                end
            endcase
            if (take_go) begin
                o_regs.state  = target;
                o_regs.status = (i_regs.status & ~dpsm_pkg::entry_clr(target))
                                | dpsm_pkg::entry_set(target);
            end
        end else if (is_mode) begin
            if (mode_ok) begin
                o_regs.active_mode = mode_byte;
            end else begin
                rejected = 1'b1;
            end
            o_regs.shown_mode = mode_byte;
        end

        o_result.stat_bits         = o_regs.status;
        o_result.drive_state       = o_regs.state;
        o_result.mode_display      = o_regs.shown_mode;
        o_result.mode_rejected     = rejected;
        o_result.halt_flag         = o_regs.halt;
        o_result.relative_flag     = o_regs.relative;
        o_result.new_setpoint_flag = o_regs.setpoint;
        o_result.motor_action      = act;
    end

endmodule

FILE: rtl/drive_power_state_machine.sv
// CiA 402 drive power state machine: one object write in, one status word out per cycle
// while the result side keeps up. The write is taken whenever the result register is
// empty or being drained; its result is registered and appears in the cycle after
// acceptance. The next-state logic in dpsm_core is combinational and feeds the single
// result register.
// Depends on dpsm_pkg, dpsm_core and drive_power_state_machine_defines.svh.
`timescale 1ns / 1ps
`include "drive_power_state_machine_defines.svh"

module drive_power_state_machine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sub_index[7:0], write_value[23:8]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // stat_bits[15:0], drive_state[18:16], mode_display[26:19], mode_rejected[27],
    // halt_flag[28], relative_flag[29], new_setpoint_flag[30], motor_action[32:31]
    output logic [39:0] m_axis_tdata
);

    dpsm_pkg::t_drive_regs r_regs;
    dpsm_pkg::t_drive_regs n_regs;
    dpsm_pkg::t_result     r_result;
    dpsm_pkg::t_result     n_result;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  in_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    dpsm_core u_core (
        .i_regs        (r_regs),
        .i_command     (s_axis_tuser),
        .i_sub_index   (s_axis_tdata[7:0]),
        .i_write_value (s_axis_tdata[23:8]),
        .o_regs        (n_regs),
        .o_result      (n_result)
    );

    always_comb begin
        priority if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                r_regs <= n_regs;
            end
        end
    end

    // result word, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_result.motor_action,
                            r_result.new_setpoint_flag,
                            r_result.relative_flag,
                            r_result.halt_flag,
                            r_result.mode_rejected,
                            r_result.mode_display,
                            r_result.drive_state,
                            r_result.stat_bits};

    `DPSM_ASSERT_NEXT(a_fire_gives_word, in_fire, r_out_valid)
    `DPSM_ASSERT_NEXT(a_state_holds_idle, !in_fire, $stable(r_regs))
    `DPSM_ASSERT_NOW(a_no_fault_states, 1'b1,
        (r_regs.state != dpsm_pkg::ST_FAULT_REACTION) && (r_regs.state != dpsm_pkg::ST_FAULT))
    `DPSM_ASSERT_NOW(a_enabled_status, r_regs.state == dpsm_pkg::ST_ENABLED,
        (r_regs.status & (dpsm_pkg::SB_OE | dpsm_pkg::SB_QS))
            == (dpsm_pkg::SB_OE | dpsm_pkg::SB_QS))
    `DPSM_ASSERT_NOW(a_reject_only_bad_mode, r_out_valid && r_result.mode_rejected,
        r_result.mode_display[7] || (r_result.mode_display > dpsm_pkg::MODE_MAX))

endmodule

FILE: test/testbench.sv
// self-checking bench for the drive power state machine: object writes in, status words out
// a predictor class tracks drive state, modes and latches; depends on dpsm_pkg and the rtl top
`timescale 1ns / 1ps

module testbench;
    import dpsm_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_WORDS = 1525;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;

    // objects the block does not handle
    localparam logic [1:0] CMD_OTHER_OBJ = 2'd2;
    localparam logic [1:0] CMD_SPARE_OBJ = 2'd3;

    // canonical control words
    localparam logic [15:0] CTL_DISABLE     = 16'h0000;
    localparam logic [15:0] CTL_QUICK_STOP  = 16'h0002;
    localparam logic [15:0] CTL_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CTL_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CTL_ENABLE      = 16'h000F;
    localparam logic [15:0] CTL_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CTL_LATCH_BITS  = 16'h0150;
    localparam logic [15:0] CTL_FREE_BITS   = 16'hFF70;

    class drive_status_tracker;
        t_drive_state state;
        logic [15:0]  status;
        logic [7:0]   active_mode;
        logic [7:0]   tracked_mode;
        logic [7:0]   shown_mode;
        logic         halt;
        logic         relative;
        logic         setpoint;
        t_result      pending[$];
        int           errors;

        function new();
            state        = ST_NOT_READY;
            status       = '0;
            active_mode  = '0;
            tracked_mode = '0;
            shown_mode   = '0;
            halt         = 1'b0;
            relative     = 1'b0;
            setpoint     = 1'b0;
            errors       = 0;
        endfunction

        function void enter(t_drive_state st);
            logic [15:0] set_m;
            logic [15:0] clr_m;
            case (st)
                ST_DISABLED: begin
                    set_m = SB_SOD;
                    clr_m = SB_RTSO | SB_SO | SB_OE | SB_FAULT;
                end
                ST_READY: begin
                    set_m = SB_RTSO | SB_QS;
                    clr_m = SB_SO | SB_OE | SB_FAULT | SB_SOD;
                end
                ST_SWITCHED_ON: begin
                    set_m = SB_RTSO | SB_SO | SB_QS;
                    clr_m = SB_OE | SB_FAULT | SB_SOD;
                end
                ST_ENABLED: begin
                    set_m = SB_RTSO | SB_SO | SB_OE | SB_QS;
                    clr_m = SB_FAULT | SB_SOD;
                end
                ST_QUICK_STOP: begin
                    set_m = SB_RTSO | SB_SO | SB_OE;
                    clr_m = SB_FAULT | SB_QS | SB_SOD;
                end
                default: begin
                    set_m = '0;
                    clr_m = '0;
                end
            endcase
            state  = st;
            status = (status & ~clr_m) | set_m;
        endfunction

        // tests run in a fixed order per state, the last match wins
        function t_motor_action apply_control_word(logic [15:0] cw);
            logic          fr;
            logic          shutdown;
            logic          no_voltage;
            logic          switch_on;
            logic          enable_op;
            logic          quick_stop;
            t_motor_action act;
            fr         = cw[CW_FR];
            shutdown   = !fr && cw[CW_QS] && cw[CW_EV] && !cw[CW_SO];
            no_voltage = !fr && !cw[CW_EV];
            switch_on  = !fr && !cw[CW_EO] && cw[CW_QS] && cw[CW_EV] && cw[CW_SO];
            enable_op  = !fr && cw[CW_EO] && cw[CW_QS] && cw[CW_EV] && cw[CW_SO];
            quick_stop = !fr && !cw[CW_QS] && cw[CW_EV];
            act        = ACT_NONE;
            case (state)
                ST_NOT_READY: enter(ST_DISABLED);
                ST_DISABLED: begin
                    if (shutdown) enter(ST_READY);
                end
                ST_READY: begin
                    if (no_voltage) enter(ST_DISABLED);
                    if (switch_on) enter(ST_SWITCHED_ON);
                    if (fr) enter(ST_READY);
                end
                ST_SWITCHED_ON: begin
                    if (no_voltage) enter(ST_DISABLED);
                    if (shutdown) enter(ST_READY);
                    if (enable_op) enter(ST_ENABLED);
                end
                ST_ENABLED: begin
                    if (no_voltage) enter(ST_DISABLED);
                    if (shutdown) enter(ST_READY);
                    if (switch_on) enter(ST_SWITCHED_ON);
                    if (quick_stop) begin
                        enter(ST_QUICK_STOP);
                        act = ACT_STOP;
                    end
                    // latches and mode tracking still run after leaving the state
                    relative = cw[CW_REL];
                    halt     = cw[CW_HALT];
                    setpoint = cw[CW_NSP];
                    if (tracked_mode != active_mode) begin
                        tracked_mode = active_mode;
                        if (active_mode == MODE_PROFILE_VEL) act = ACT_VEL;
                        else if (active_mode == MODE_PROFILE_TRQ) act = ACT_TRQ;
                        else act = ACT_STOP;
                    end
                end
                ST_QUICK_STOP: begin
                    if (enable_op) enter(ST_ENABLED);
                    if (no_voltage) enter(ST_DISABLED);
                end
                default: ;
            endcase
            return act;
        endfunction

        function void note_write(logic [1:0] cmd, logic [7:0] sub, logic [15:0] val);
            t_result r;
            r.motor_action  = ACT_NONE;
            r.mode_rejected = 1'b0;
            if (sub == '0 && cmd == CMD_CONTROL_WORD) begin
                r.motor_action = apply_control_word(val);
            end else if (sub == '0 && cmd == CMD_OP_MODE) begin
                // mode is a signed byte, only 0..MODE_MAX is stored
                if (!val[7] && val[7:0] <= MODE_MAX) active_mode = val[7:0];
                else r.mode_rejected = 1'b1;
                shown_mode = val[7:0];
            end
            r.stat_bits         = status;
            r.drive_state       = state;
            r.mode_display      = shown_mode;
            r.halt_flag         = halt;
            r.relative_flag     = relative;
            r.new_setpoint_flag = setpoint;
            pending.push_back(r);
        endfunction

        task report_mismatch(string field, logic [39:0] got, logic [39:0] exp);
            $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, exp);
            errors++;
        endtask

        task check_status(logic [39:0] word);
            t_result want;
            if (pending.size() == 0) begin
                report_mismatch("word with nothing expected", word, '0);
                return;
            end
            want = pending.pop_front();
            if (word[15:0] !== want.stat_bits)
                report_mismatch("stat_bits", 40'(word[15:0]), 40'(want.stat_bits));
            if (word[18:16] !== want.drive_state)
                report_mismatch("drive_state", 40'(word[18:16]), 40'(want.drive_state));
            if (word[26:19] !== want.mode_display)
                report_mismatch("mode_display", 40'(word[26:19]), 40'(want.mode_display));
            if (word[27] !== want.mode_rejected)
                report_mismatch("mode_rejected", 40'(word[27]), 40'(want.mode_rejected));
            if (word[28] !== want.halt_flag)
                report_mismatch("halt_flag", 40'(word[28]), 40'(want.halt_flag));
            if (word[29] !== want.relative_flag)
                report_mismatch("relative_flag", 40'(word[29]), 40'(want.relative_flag));
            if (word[30] !== want.new_setpoint_flag)
                report_mismatch("new_setpoint_flag", 40'(word[30]),
                                40'(want.new_setpoint_flag));
            if (word[32:31] !== want.motor_action)
                report_mismatch("motor_action", 40'(word[32:31]), 40'(want.motor_action));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // sub_index[7:0], write_value[23:8]
    logic [1:0]  s_axis_tuser  = '0;  // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // stat_bits[15:0], drive_state[18:16], mode_display[26:19], mode_rejected[27],
    // halt_flag[28], relative_flag[29], new_setpoint_flag[30], motor_action[32:31]
    logic [39:0] m_axis_tdata;

    drive_status_tracker sb;
    int send_idle_pct = 20;
    int recv_idle_pct = 62;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    drive_power_state_machine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check each delivered word, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
        if (hold_seen != hold_seq) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic offer_write(input logic [1:0] cmd, input logic [7:0] sub,
                               input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, sub};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_write(cmd, sub, val);
    endtask

    initial begin
        int          i;
        int          roll;
        logic [1:0]  cmd;
        logic [7:0]  sub;
        logic [15:0] val;
        logic [15:0] base;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the power states, mode changes and ignored writes
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_DISABLE);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_SHUTDOWN);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_FAULT_RESET | CTL_SHUTDOWN);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_SWITCH_ON);
        offer_write(CMD_OP_MODE, 8'h00, {8'h00, MODE_PROFILE_VEL});
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_ENABLE);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_ENABLE | CTL_LATCH_BITS);
        offer_write(CMD_OP_MODE, 8'h00, {8'h00, MODE_PROFILE_TRQ});
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_ENABLE);
        offer_write(CMD_OP_MODE, 8'h00, 16'h00FF);
        offer_write(CMD_OP_MODE, 8'h00, {8'h00, MODE_MAX + 8'd1});
        offer_write(CMD_OP_MODE, 8'h00, 16'hFF80);
        offer_write(CMD_OP_MODE, 8'h00, 16'h007F);
        offer_write(CMD_OP_MODE, 8'h00, {8'hAB, MODE_MAX});
        offer_write(CMD_OP_MODE, 8'h00, {8'h00, MODE_PROFILE_VEL});
        // quick stop while the mode changed: stop is raised to a velocity restart
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_QUICK_STOP);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_ENABLE);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_DISABLE);
        offer_write(CMD_OTHER_OBJ, 8'h00, 16'hFFFF);
        offer_write(CMD_SPARE_OBJ, 8'h00, CTL_SHUTDOWN);
        offer_write(CMD_CONTROL_WORD, 8'hFF, CTL_SHUTDOWN);
        offer_write(CMD_OP_MODE, 8'h01, {8'h00, MODE_PROFILE_TRQ});
        offer_write(CMD_CONTROL_WORD, 8'h00, 16'hFFFF);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_SHUTDOWN);
        offer_write(CMD_CONTROL_WORD, 8'h00, CTL_DISABLE);

        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                send_idle_pct = 62;
                recv_idle_pct <= 20;
            end
            if (i == RANDOM_WORDS / 2) begin
                // let the block drain completely before going on
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending.size() != 0);
            end
            if (i == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (i == 2 * RANDOM_WORDS / 3 + 10) hold_seq <= hold_seq + 1;

            roll = $urandom_range(99);
            if (roll < 8) cmd = $urandom_range(1) ? CMD_OTHER_OBJ : CMD_SPARE_OBJ;
            else if (roll < 33) cmd = CMD_OP_MODE;
            else cmd = CMD_CONTROL_WORD;
            sub = ($urandom_range(99) < 6) ? 8'($urandom_range(255, 1)) : 8'h00;
            val = 16'($urandom);
            if (cmd == CMD_OP_MODE && $urandom_range(99) < 80) begin
                val[7:0] = 8'($urandom_range(MODE_MAX));
            end else if (cmd == CMD_CONTROL_WORD && $urandom_range(99) < 80) begin
                case ($urandom_range(9))
                    0:       base = CTL_DISABLE;
                    1:       base = CTL_QUICK_STOP;
                    2, 3:    base = CTL_SHUTDOWN;
                    4, 5:    base = CTL_SWITCH_ON;
                    9:       base = CTL_FAULT_RESET;
                    default: base = CTL_ENABLE;
                endcase
                // clean command bits, random setpoint/relative/halt and spare bits
                val = base | (val & CTL_FREE_BITS);
            end
            offer_write(cmd, sub, val);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (4) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch("results never delivered", 40'(sb.pending.size()), '0);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
